@@ rtl/core/cmperm_pkg.sv @@
// Shared constants for the circulant matrix permanent unit.
package cmperm_pkg;

	// Default matrix bound and circulant size
	localparam int DEF_MAX_SIZE       = 16;
	localparam int DEF_CIRCULANT_SIZE = 64;

	// Fixed field widths of the ports
	localparam int SIZE_W   = 5;
	localparam int INDEX_W  = 4;
	localparam int EXP_W    = 7;
	localparam int RESULT_W = 64;

	// Request codes on the action field
	localparam logic ACT_WRITE   = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

endpackage

@@ rtl/core/cmperm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cmperm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ rtl/core/circulant_matrix_permanent_unit.sv @@
// Circulant matrix permanent over GF(2)[x]/(x^Q - 1) by backtracking permutation search.
// A write request (action 0) stores one circulant exponent in the entry RAM; it is taken
// even while a finished result still waits on the output. A compute request (action 1)
// walks every column permutation of the leading matrix_size square that uses only present
// entries, adding exponents modulo CIRCULANT_SIZE and toggling that bit of the result.
// The search is run by a small sequencer around one shared modular adder and the entry
// RAM's single read port: a candidate column that is already taken is skipped, a free
// one has its entry read and then evaluated, a row with no columns left steps back up a
// row, and the request ends in a done state that waits while an earlier result is still
// stalled on the output. Input stall stays high for the whole search. Entries inside the
// matrix in use must have been written before a compute request.
module circulant_matrix_permanent_unit #(
	parameter int MAX_SIZE       = cmperm_pkg::DEF_MAX_SIZE,
	parameter int CIRCULANT_SIZE = cmperm_pkg::DEF_CIRCULANT_SIZE
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration port
	input  logic                                  cfg_wr_en,
	input  logic [cmperm_pkg::SIZE_W-1:0]         cfg_wr_data,
	// request channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  action,
	input  logic [cmperm_pkg::INDEX_W-1:0]        row_index,
	input  logic [cmperm_pkg::INDEX_W-1:0]        col_index,
	input  logic signed [cmperm_pkg::EXP_W-1:0]   exponent,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [cmperm_pkg::RESULT_W-1:0]       permanent_bits
);

	localparam int IDX_W   = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CNT_W   = $clog2(MAX_SIZE + 1);
	localparam int DEPTH   = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SUM_W   = (CIRCULANT_SIZE > 1) ? $clog2(CIRCULANT_SIZE) : 1;
	localparam int RAW_W   = cmperm_pkg::EXP_W - 1;
	localparam int RAW_NUM = 2 ** RAW_W;

	// Sequencer codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_TRY  = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                state_q;
	logic [cmperm_pkg::SIZE_W-1:0] matrix_size_q;
	logic [CNT_W-1:0]          n_q;
	logic [IDX_W-1:0]          d_q;
	logic [CNT_W-1:0]          c_q;
	logic [MAX_SIZE-1:0]       used_q;
	logic [IDX_W-1:0]          col_stk_q [MAX_SIZE];
	logic [SUM_W-1:0]          psum_q [MAX_SIZE];
	logic [CIRCULANT_SIZE-1:0] acc_q;
	logic [cmperm_pkg::RESULT_W-1:0] out_data_q;
	logic                      out_valid_q;

	logic                      in_accept;
	logic                      wr_en;
	logic [ADDR_W-1:0]         wr_addr;
	logic                      rd_en;
	logic [ADDR_W-1:0]         rd_addr;
	logic [cmperm_pkg::EXP_W-1:0] rd_data;
	logic [IDX_W-1:0]          c_idx;
	logic [IDX_W-1:0]          d_prev;
	logic [IDX_W-1:0]          d_next;
	logic                      last_row;
	logic [SUM_W-1:0]          mod_tbl [RAW_NUM];
	logic [SUM_W-1:0]          e_mod;
	logic [SUM_W:0]            sum_w;
	logic [SUM_W-1:0]          sum_mod;
	logic [CNT_W-1:0]          n_clamp;
	logic                      out_free;

	// Reduction table for raw exponents, fixed at elaboration
	for (genvar g = 0; g < RAW_NUM; g++) begin : g_mod_tbl
		localparam int MV = g % CIRCULANT_SIZE;
		assign mod_tbl[g] = SUM_W'(MV);
	end

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	// Entry writes, dropped when the index lies beyond the store
	assign wr_en   = in_accept && (action == cmperm_pkg::ACT_WRITE)
	                 && (32'(row_index) < MAX_SIZE) && (32'(col_index) < MAX_SIZE);
	assign wr_addr = ADDR_W'(ADDR_W'(row_index) * ADDR_W'(MAX_SIZE) + ADDR_W'(col_index));

	// Search helpers
	assign c_idx    = c_q[IDX_W-1:0];
	assign d_prev   = d_q - IDX_W'(1);
	assign d_next   = d_q + IDX_W'(1);
	assign last_row = (CNT_W'(d_q) == (n_q - CNT_W'(1)));
	assign rd_en    = (state_q == S_TRY) && (c_q < n_q) && !used_q[c_idx];
	assign rd_addr  = ADDR_W'(ADDR_W'(d_q) * ADDR_W'(MAX_SIZE) + ADDR_W'(c_idx));

	// Shared modular adder: partial sum plus reduced exponent
	assign e_mod   = mod_tbl[rd_data[RAW_W-1:0]];
	assign sum_w   = (SUM_W+1)'(psum_q[d_q]) + (SUM_W+1)'(e_mod);
	assign sum_mod = (sum_w >= (SUM_W+1)'(CIRCULANT_SIZE))
	                 ? SUM_W'(sum_w - (SUM_W+1)'(CIRCULANT_SIZE)) : SUM_W'(sum_w);

	// Matrix size in use, clamped to one and to the bound
	always_comb begin
		if (matrix_size_q == '0) begin
			n_clamp = CNT_W'(1);
		end else if (32'(matrix_size_q) > MAX_SIZE) begin
			n_clamp = CNT_W'(MAX_SIZE);
		end else begin
			n_clamp = CNT_W'(matrix_size_q);
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	cmperm_ram #(
		.WIDTH (cmperm_pkg::EXP_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ($unsigned(exponent)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			matrix_size_q <= cmperm_pkg::SIZE_W'(1);
		end else if (cfg_wr_en) begin
			matrix_size_q <= cfg_wr_data;
		end
	end

	// Search sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q     <= CNT_W'(1);
			d_q     <= '0;
			c_q     <= '0;
			used_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_accept && (action == cmperm_pkg::ACT_COMPUTE)) begin
						n_q     <= n_clamp;
						d_q     <= '0;
						c_q     <= '0;
						used_q  <= '0;
						state_q <= S_TRY;
					end
				end
				S_TRY: begin
					if (c_q >= n_q) begin
						if (d_q == '0) begin
							state_q <= S_DONE;
						end else begin
							// step back: release the column chosen one row up
							d_q                     <= d_prev;
							c_q                     <= CNT_W'(col_stk_q[d_prev]) + CNT_W'(1);
							used_q[col_stk_q[d_prev]] <= 1'b0;
						end
					end else if (used_q[c_idx]) begin
						c_q <= c_q + CNT_W'(1);
					end else begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					state_q <= S_TRY;
					if (rd_data[cmperm_pkg::EXP_W-1] || last_row) begin
						c_q <= c_q + CNT_W'(1);
					end else begin
						// descend one row with this column taken
						used_q[c_idx] <= 1'b1;
						d_q           <= d_next;
						c_q           <= '0;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Stacks and accumulator
	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && in_accept && (action == cmperm_pkg::ACT_COMPUTE)) begin
			psum_q[0] <= '0;
			acc_q     <= '0;
		end
		if ((state_q == S_EVAL) && !rd_data[cmperm_pkg::EXP_W-1]) begin
			if (last_row) begin
				acc_q[sum_mod] <= ~acc_q[sum_mod];
			end else begin
				col_stk_q[d_q] <= c_idx;
				psum_q[d_next] <= sum_mod;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			out_data_q <= cmperm_pkg::RESULT_W'(acc_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign permanent_bits = out_data_q;

	// Checks
	a_used_matches_depth: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_TRY) || (state_q == S_EVAL)) |-> ($countones(used_q) == int'(d_q)))
		else $error("taken columns do not match search depth");

	a_depth_in_matrix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (CNT_W'(d_q) < n_q))
		else $error("search depth beyond matrix size");

	a_eval_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EVAL) |-> ($past(state_q) == S_TRY))
		else $error("entry evaluated without a read");

endmodule
